// ===== design/rcpc_pkg.sv =====
package rcpc_pkg;

    // Item kinds carried in the mode field
    localparam logic [1:0] MODE_EDGE    = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_REQUEST = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
    localparam logic [2:0] REG_ABS_MIN_US   = 3'd1;
    localparam logic [2:0] REG_ABS_MAX_US   = 3'd2;
    localparam logic [2:0] REG_IDLE_US      = 3'd3;
    localparam logic [2:0] REG_MOTOR_ON_US  = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_MS   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_FRAME_PERIOD = 16'd20000;
    localparam logic [15:0] RST_ABS_MIN_US   = 16'd800;
    localparam logic [15:0] RST_ABS_MAX_US   = 16'd2200;
    localparam logic [15:0] RST_IDLE_US      = 16'd1000;
    localparam logic [15:0] RST_MOTOR_ON_US  = 16'd1100;
    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd100;

    // Loss timer saturates one past the largest timeout
    localparam int          MS_W   = 17;
    localparam logic [MS_W-1:0] MS_MAX = {1'b1, {(MS_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]  mode;
        logic        pin_level;
        logic [15:0] capture_count;
        logic [15:0] request_us;
    } t_in_item;

    typedef struct packed {
        logic [15:0] output_us;
        logic [15:0] good_width_us;
        logic        signal_valid;
        logic        armed;
        logic        motor_on;
    } t_out_item;

    typedef struct packed {
        logic [15:0] frame_period;
        logic [15:0] abs_min_us;
        logic [15:0] abs_max_us;
        logic [15:0] idle_us;
        logic [15:0] motor_on_us;
        logic [15:0] timeout_ms;
    } t_cfg;

endpackage

// ===== design/rcpc_core.sv =====
module rcpc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  rcpc_pkg::t_in_item   i_item,
    input  rcpc_pkg::t_cfg       i_cfg,
    output rcpc_pkg::t_out_item  o_result
);

    logic                      r_got_rising, n_got_rising;
    logic [15:0]               r_rising_count, n_rising_count;
    logic [15:0]               r_last_good_us, n_last_good_us;
    logic [rcpc_pkg::MS_W-1:0] r_ms_since_good, n_ms_since_good;
    logic                      r_valid_flag, n_valid_flag;
    logic                      r_armed_flag, n_armed_flag;
    logic [15:0]               r_drive_us, n_drive_us;

    logic [17:0]               w_wrap_sum;
    logic [15:0]               w_width;
    logic                      w_width_ok;
    logic                      w_width_good;
    logic                      w_req_good;
    logic [rcpc_pkg::MS_W-1:0] w_ms_inc;

    // Measure width, wrapping over the frame period; drop anything above 16 bits
    always_comb begin
        w_wrap_sum = {2'b00, i_cfg.frame_period} - {2'b00, r_rising_count}
                     + {2'b00, i_item.capture_count};
        if (i_item.capture_count >= r_rising_count) begin
            w_width    = i_item.capture_count - r_rising_count;
            w_width_ok = 1'b1;
        end else begin
            w_width    = w_wrap_sum[15:0];
            w_width_ok = (w_wrap_sum[17:16] == 2'b00);
        end
        w_width_good = w_width_ok && (w_width >= i_cfg.abs_min_us)
                       && (w_width <= i_cfg.abs_max_us);
        w_req_good   = (i_item.request_us >= i_cfg.abs_min_us)
                       && (i_item.request_us <= i_cfg.abs_max_us);
        w_ms_inc     = (r_ms_since_good == rcpc_pkg::MS_MAX) ? r_ms_since_good
                       : r_ms_since_good + 1'b1;
    end

    // Next state for the item at the input
    always_comb begin
        n_got_rising    = r_got_rising;
        n_rising_count  = r_rising_count;
        n_last_good_us  = r_last_good_us;
        n_ms_since_good = r_ms_since_good;
        n_valid_flag    = r_valid_flag;
        n_armed_flag    = r_armed_flag;
        n_drive_us      = r_drive_us;
        unique case (i_item.mode)
            rcpc_pkg::MODE_EDGE: begin
                if (i_item.pin_level) begin
                    n_rising_count = i_item.capture_count;
                    n_got_rising   = 1'b1;
                end else begin
                    if (r_got_rising && w_width_good) begin
                        n_last_good_us  = w_width;
                        n_ms_since_good = '0;
                        n_valid_flag    = 1'b1;
                        if (!r_armed_flag && (w_width < i_cfg.motor_on_us)) begin
                            n_armed_flag = 1'b1;
                        end
                    end
                    n_got_rising = 1'b0;
                end
            end
            rcpc_pkg::MODE_TICK: begin
                n_ms_since_good = w_ms_inc;
                if (!r_valid_flag || (w_ms_inc > {1'b0, i_cfg.timeout_ms})) begin
                    n_valid_flag = 1'b0;
                    n_armed_flag = 1'b0;
                    n_drive_us   = i_cfg.idle_us;
                end
            end
            rcpc_pkg::MODE_REQUEST: begin
                n_drive_us = w_req_good ? i_item.request_us : i_cfg.idle_us;
            end
            default: begin
            end
        endcase
    end

    // Report the state as it stands after this item
    always_comb begin
        o_result.output_us     = n_drive_us;
        o_result.good_width_us = n_last_good_us;
        o_result.signal_valid  = n_valid_flag;
        o_result.armed         = n_armed_flag;
        o_result.motor_on      = n_valid_flag && n_armed_flag
                                 && (n_last_good_us >= i_cfg.motor_on_us);
    end

    // Advance state on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_got_rising    <= 1'b0;
            r_rising_count  <= '0;
            r_last_good_us  <= rcpc_pkg::RST_IDLE_US;
            r_ms_since_good <= '0;
            r_valid_flag    <= 1'b0;
            r_armed_flag    <= 1'b0;
            r_drive_us      <= rcpc_pkg::RST_IDLE_US;
        end else if (i_accept) begin
            r_got_rising    <= n_got_rising;
            r_rising_count  <= n_rising_count;
            r_last_good_us  <= n_last_good_us;
            r_ms_since_good <= n_ms_since_good;
            r_valid_flag    <= n_valid_flag;
            r_armed_flag    <= n_armed_flag;
            r_drive_us      <= n_drive_us;
        end
    end

endmodule

// ===== design/rc_pulse_capture_arming_failsafe.sv =====
// Results of accepted inputs are registered (output register, else skid register).
// One item per cycle unless stalled; the update is a single compare/subtract pass.
// A two-entry output (result register plus skid register) keeps the input stall
// registered, so input is held off only when both entries are full.
// Reset (synchronous, active low) restores all configuration registers to their
// defaults, clears the capture and failsafe state and empties the output.
module rc_pulse_capture_arming_failsafe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rcpc_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rcpc_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    rcpc_pkg::t_cfg       r_cfg;
    rcpc_pkg::t_out_item  w_result;
    rcpc_pkg::t_out_item  r_out;
    rcpc_pkg::t_out_item  r_skid;
    logic                 r_out_valid;
    logic                 r_skid_valid;
    logic                 w_in_acc;
    logic                 w_out_acc;

    assign w_in_acc    = i_in_valid && !r_skid_valid;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_period <= rcpc_pkg::RST_FRAME_PERIOD;
            r_cfg.abs_min_us   <= rcpc_pkg::RST_ABS_MIN_US;
            r_cfg.abs_max_us   <= rcpc_pkg::RST_ABS_MAX_US;
            r_cfg.idle_us      <= rcpc_pkg::RST_IDLE_US;
            r_cfg.motor_on_us  <= rcpc_pkg::RST_MOTOR_ON_US;
            r_cfg.timeout_ms   <= rcpc_pkg::RST_TIMEOUT_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcpc_pkg::REG_FRAME_PERIOD: r_cfg.frame_period <= i_cfg_data;
                rcpc_pkg::REG_ABS_MIN_US:   r_cfg.abs_min_us   <= i_cfg_data;
                rcpc_pkg::REG_ABS_MAX_US:   r_cfg.abs_max_us   <= i_cfg_data;
                rcpc_pkg::REG_IDLE_US:      r_cfg.idle_us      <= i_cfg_data;
                rcpc_pkg::REG_MOTOR_ON_US:  r_cfg.motor_on_us  <= i_cfg_data;
                rcpc_pkg::REG_TIMEOUT_MS:   r_cfg.timeout_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rcpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_acc),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Output register with skid: refill from skid first, else from the new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_acc || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (w_in_acc) begin
                    r_out       <= w_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_in_acc) begin
                r_skid       <= w_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule
